/* sv/prm_pkg.sv */
// Package for the pixel rotation mapper: request/result payload types and
// the elaboration-time Q1.14 sine/cosine generator. No dependencies.
`default_nettype none

package prm_pkg;

    localparam int ANGLE_W = 9;
    localparam int TRIG_W  = 16;   // signed Q1.14, range -16384..16384
    localparam int FRAC_Q  = 14;
    localparam int QUAD_N  = 90;   // entries in the quarter-wave table
    localparam int QIDX_W  = 7;

    localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

    localparam logic [63:0]  PI_NUM     = 64'd3141592654;
    localparam logic [127:0] PI_DEN_DEG = 128'd180000000000;

    typedef struct packed {
        logic [6:0] src_row;
        logic [6:0] src_col;
        logic [7:0] pixel_value;
    } pix_req_t;

    typedef struct packed {
        logic [6:0] dst_row;
        logic [6:0] dst_col;
        logic [7:0] dst_value;
        logic       in_range;
    } pix_res_t;

    // (a*b) >> 60, Q4.60 product
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // restoring shift-subtract divide, constant use only
    function automatic logic [127:0] udiv_sweep(input logic [127:0] n,
                                                input logic [127:0] d);
        logic [127:0] rem;
        logic [127:0] q;
        rem = '0;
        q   = '0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[126:0], n[i]};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin (want_cos=0) or cos (want_cos=1) of r degrees, r in 0..89, Q1.14
    function automatic logic signed [TRIG_W-1:0] trig_q14(input int r, input bit want_cos);
        logic [127:0] num;
        logic [63:0]  t;
        logic [63:0]  t2;
        logic [63:0]  s;
        logic [63:0]  st;
        logic [63:0]  c;
        logic [63:0]  ct;
        logic [63:0]  v;
        logic [127:0] div_q;
        num = 128'(64'(r) * PI_NUM) << 60;
        div_q = udiv_sweep(num, PI_DEN_DEG);
        t  = div_q[63:0];
        t2 = q60_mul(t, t);
        s  = t;
        st = t;
        c  = 64'd1 << 60;
        ct = 64'd1 << 60;
        for (int n = 1; n <= 14; n++) begin
            div_q = udiv_sweep({64'd0, q60_mul(st, t2)}, 128'((2 * n) * (2 * n + 1)));
            st = div_q[63:0];
            div_q = udiv_sweep({64'd0, q60_mul(ct, t2)}, 128'((2 * n - 1) * (2 * n)));
            ct = div_q[63:0];
            if ((n % 2) == 1) begin
                s = s - st;
                c = c - ct;
            end else begin
                s = s + st;
                c = c + ct;
            end
        end
        v = want_cos ? c : s;
        v = (v + (64'd1 << 45)) >> 46;
        return signed'(v[TRIG_W-1:0]);
    endfunction

endpackage

`default_nettype wire

/* sv/pixel_rotation_mapper_top.sv */
// Pixel rotation mapper top level: angle register and three-stage
// rotate pipeline. Depends on prm_pkg and prm_trig_rom.
`default_nettype none

// Channel     Ports                              Direction  Handshake
// ---------   --------------------------------   ---------  --------------------------
// request     start, busy, req (pix_req_t)       in         taken when start && !busy
// result      done, result (pix_res_t)           out        one-cycle strobe, no stall
// config      cfg_valid, cfg_ready, cfg_data     in         written when valid && ready
//
// One request per clock; each result passes through the input/trig stage, the
// multiplier stage and the sum/range stage after its request is taken.
// busy and cfg_ready are always low and high: nothing in the path can back up.
// rst_n clears the stage valid bits and sets the angle to 0 degrees.
// The receiver cannot stall, so results are never held or repeated.
module pixel_rotation_mapper_top
    import prm_pkg::*;
#(
    parameter int CANVAS_SIZE = 128
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire pix_req_t           req,
    output logic                    done,
    output pix_res_t                result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [ANGLE_W-1:0] cfg_data
);

    localparam int HALF = CANVAS_SIZE / 2;
    // centered coordinate: -HALF .. 127 - HALF
    localparam int XW = $clog2(HALF + 128) + 1;
    localparam int PW = XW + TRIG_W;       // one product
    localparam int SW = PW + 1;            // sum of two products
    localparam int RW = SW - FRAC_Q + 1;   // destination coordinate after recentering

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // angle register
    logic [ANGLE_W-1:0] angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            angle_reg <= cfg_data;
        end
    end

    // trig lookup feeds stage 1
    logic signed [TRIG_W-1:0] sin_now;
    logic signed [TRIG_W-1:0] cos_now;

    prm_trig_rom u_trig (
        .angle (angle_reg),
        .sin_q (sin_now),
        .cos_q (cos_now)
    );

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg;
    logic take;

    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: center coordinates, latch sin/cos
    logic signed [XW-1:0]     x_next, y_next;
    logic signed [XW-1:0]     x_reg, y_reg;
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;
    logic [7:0]               val1_reg;

    assign x_next = XW'(req.src_col) - XW'(HALF);
    assign y_next = XW'(req.src_row) - XW'(HALF);

    // stage 2: the four products
    logic signed [PW-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic [7:0]           val2_reg;

    // stage 3: sums, floor by arithmetic shift, recenter, range check
    logic signed [SW-1:0] xr_sum, yr_sum;
    logic signed [RW-1:0] row_c, col_c;
    logic                 ok_c;
    pix_res_t             res_next;
    pix_res_t             res_reg;

    always_comb
    begin
        xr_sum = SW'(xc_reg) - SW'(ys_reg);
        yr_sum = SW'(xs_reg) + SW'(yc_reg);
        row_c  = RW'(signed'(yr_sum[SW-1:FRAC_Q])) + RW'(HALF);
        col_c  = RW'(signed'(xr_sum[SW-1:FRAC_Q])) + RW'(HALF);
        ok_c   = !row_c[RW-1] && !col_c[RW-1]
                 && (row_c < RW'(CANVAS_SIZE)) && (col_c < RW'(CANVAS_SIZE));
        res_next.dst_row   = ok_c ? row_c[6:0] : 7'd0;
        res_next.dst_col   = ok_c ? col_c[6:0] : 7'd0;
        res_next.dst_value = val2_reg;
        res_next.in_range  = ok_c;
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            sin_reg  <= sin_now;
            cos_reg  <= cos_now;
            val1_reg <= req.pixel_value;
        end
        if (v1_reg)
        begin
            xc_reg   <= PW'(x_reg) * PW'(cos_reg);
            ys_reg   <= PW'(y_reg) * PW'(sin_reg);
            xs_reg   <= PW'(x_reg) * PW'(sin_reg);
            yc_reg   <= PW'(y_reg) * PW'(cos_reg);
            val2_reg <= val1_reg;
        end
        if (v2_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = v3_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

/* sv/prm_trig_rom.sv */
// Angle to sine/cosine lookup: quarter-wave constant table plus quadrant fold.
// Depends on prm_pkg.
`default_nettype none

module prm_trig_rom
    import prm_pkg::*;
(
    input  wire logic        [ANGLE_W-1:0] angle,
    output logic signed      [TRIG_W-1:0]  sin_q,
    output logic signed      [TRIG_W-1:0]  cos_q
);

    logic signed [TRIG_W-1:0] sin_tab [QUAD_N];
    logic signed [TRIG_W-1:0] cos_tab [QUAD_N];

    for (genvar k = 0; k < QUAD_N; k++) begin : g_tab
        localparam logic signed [TRIG_W-1:0] SIN_K = trig_q14(k, 1'b0);
        localparam logic signed [TRIG_W-1:0] COS_K = trig_q14(k, 1'b1);
        assign sin_tab[k] = SIN_K;
        assign cos_tab[k] = COS_K;
    end

    logic [ANGLE_W-1:0] ang_mod;
    logic [ANGLE_W-1:0] ang_r;
    logic [1:0]         quad;
    logic signed [TRIG_W-1:0] sq;
    logic signed [TRIG_W-1:0] cq;

    always_comb
    begin
        ang_mod = (angle >= DEG_360) ? angle - DEG_360 : angle;
        priority if (ang_mod >= DEG_270)
        begin
            quad  = 2'd3;
            ang_r = ang_mod - DEG_270;
        end
        else if (ang_mod >= DEG_180)
        begin
            quad  = 2'd2;
            ang_r = ang_mod - DEG_180;
        end
        else if (ang_mod >= DEG_90)
        begin
            quad  = 2'd1;
            ang_r = ang_mod - DEG_90;
        end
        else
        begin
            quad  = 2'd0;
            ang_r = ang_mod;
        end
        sq = sin_tab[ang_r[QIDX_W-1:0]];
        cq = cos_tab[ang_r[QIDX_W-1:0]];
        unique case (quad)
            2'd0:
            begin
                sin_q = sq;
                cos_q = cq;
            end
            2'd1:
            begin
                sin_q = cq;
                cos_q = -sq;
            end
            2'd2:
            begin
                sin_q = -sq;
                cos_q = -cq;
            end
            default:
            begin
                sin_q = -cq;
                cos_q = sq;
            end
        endcase
    end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for pixel_rotation_mapper_top: random and directed
// pixel requests across many angle settings, checked against a built-in predictor.
// Depends on prm_pkg (payload types, ANGLE_W) and the RTL top level.
`timescale 1ns / 100ps

module testbench;
    import prm_pkg::*;

    localparam int  CANVAS      = 128;
    localparam int  HALF        = CANVAS / 2;
    localparam int  PIPE_DEPTH  = 3;        // stages from request to result
    localparam int  CYCLE_LIMIT = 200000;   // watchdog limit on the run
    localparam int  RAND_PHASES = 10;
    localparam int  RAND_PER_PHASE = 50;

    // Reference trig terms: pi to nine places, scaled so r*PI/DIV is radians
    localparam logic [63:0]  PI_BILLIONTHS = 64'd3141592654;
    localparam logic [127:0] RAD_DIV       = 128'd180000000000;

    // ------------------------------------------------------------------
    // Rotation scoreboard: predicts each mapped pixel at request time and
    // compares the results in order.
    // ------------------------------------------------------------------
    class rotation_scoreboard;
        int                sin_q14 [360];
        int                cos_q14 [360];
        logic [ANGLE_W-1:0] angle;
        pix_res_t          expected_pixels [$];
        int                errors;
        int                requests;
        int                results;

        function new();
            angle    = '0;
            errors   = 0;
            requests = 0;
            results  = 0;
            build_trig();
        endfunction

        // Q4.60 product, truncated
        function logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
            logic [127:0] prod;
            prod = 128'(a) * 128'(b);
            return 64'(prod >> 60);
        endfunction

        // Taylor series per degree of the first quadrant, folded into the
        // other three; rounded to Q1.14, halves up.
        function void build_trig();
            logic [127:0] num;
            logic [63:0]  t;
            logic [63:0]  t2;
            logic [63:0]  s;
            logic [63:0]  st;
            logic [63:0]  c;
            logic [63:0]  ct;
            int           quad;
            int           r;
            int           sq;
            int           cq;
            for (int k = 0; k < 360; k++)
            begin
                quad = k / 90;
                r    = k % 90;
                num  = (128'(r) * 128'(PI_BILLIONTHS)) << 60;
                t    = 64'(num / RAD_DIV);
                t2   = mul_q60(t, t);
                s    = t;
                st   = t;
                c    = 64'd1 << 60;
                ct   = 64'd1 << 60;
                for (int n = 1; n <= 14; n++)
                begin
                    st = mul_q60(st, t2) / 64'((2 * n) * (2 * n + 1));
                    ct = mul_q60(ct, t2) / 64'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                    begin
                        s = s - st;
                        c = c - ct;
                    end
                    else
                    begin
                        s = s + st;
                        c = c + ct;
                    end
                end
                sq = int'((s + (64'd1 << 45)) >> 46);
                cq = int'((c + (64'd1 << 45)) >> 46);
                case (quad)
                    0: begin sin_q14[k] = sq;  cos_q14[k] = cq;  end
                    1: begin sin_q14[k] = cq;  cos_q14[k] = -sq; end
                    2: begin sin_q14[k] = -sq; cos_q14[k] = -cq; end
                    default: begin sin_q14[k] = -cq; cos_q14[k] = sq; end
                endcase
            end
        endfunction

        function void set_angle(logic [ANGLE_W-1:0] deg);
            angle = deg;
        endfunction

        function pix_res_t map_pixel(pix_req_t p);
            int       a;
            longint   x;
            longint   y;
            longint   sn;
            longint   cs;
            longint   xr;
            longint   yr;
            longint   row;
            longint   col;
            pix_res_t r;
            a   = int'(angle) % 360;
            sn  = sin_q14[a];
            cs  = cos_q14[a];
            y   = longint'(p.src_row) - HALF;
            x   = longint'(p.src_col) - HALF;
            xr  = (x * cs - y * sn) >>> 14;     // arithmetic shift = floor
            yr  = (x * sn + y * cs) >>> 14;
            row = yr + HALF;
            col = xr + HALF;
            r.dst_value = p.pixel_value;
            if (row >= 0 && col >= 0 && row < CANVAS && col < CANVAS)
            begin
                r.dst_row  = row[6:0];
                r.dst_col  = col[6:0];
                r.in_range = 1'b1;
            end
            else
            begin
                r.dst_row  = '0;
                r.dst_col  = '0;
                r.in_range = 1'b0;
            end
            return r;
        endfunction

        function void note_request(pix_req_t p);
            expected_pixels.push_back(map_pixel(p));
            requests++;
        endfunction

        function void check_result(pix_res_t got);
            pix_res_t want;
            results++;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result row=%0d col=%0d val=%0d in_range=%0b",
                         $time, got.dst_row, got.dst_col, got.dst_value, got.in_range);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.dst_row !== want.dst_row)
            begin
                $display("%0t: dst_row expected %0d actual %0d", $time, want.dst_row,
                         got.dst_row);
                errors++;
            end
            if (got.dst_col !== want.dst_col)
            begin
                $display("%0t: dst_col expected %0d actual %0d", $time, want.dst_col,
                         got.dst_col);
                errors++;
            end
            if (got.dst_value !== want.dst_value)
            begin
                $display("%0t: dst_value expected %0d actual %0d", $time, want.dst_value,
                         got.dst_value);
                errors++;
            end
            if (got.in_range !== want.in_range)
            begin
                $display("%0t: in_range expected %0b actual %0b", $time, want.in_range,
                         got.in_range);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    pix_req_t           req;
    logic               done;
    pix_res_t           result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [ANGLE_W-1:0] cfg_data;

    rotation_scoreboard sb;
    int                 ncycles;
    int                 angle_writes;
    bit                 idle_on;

    pixel_rotation_mapper_top #(
        .CANVAS_SIZE (CANVAS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Monitors: everything is sampled at the rising edge, before the
    // block's own registers update, so handshakes are seen as the DUT sees them.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.set_angle(cfg_data);
                angle_writes++;
            end
            if (start && !busy)
                sb.note_request(req);
            if (done)
                sb.check_result(result);
        end
    end

    // Watchdog: hang or lost handshake ends the run
    always @(posedge clk)
    begin
        ncycles++;
        if (ncycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, ncycles, sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // One pixel request; start is left high (unless an idle gap follows) so back-to-back
    // requests need no second assignment in the same step.
    task automatic send_pixel(input logic [6:0] row, input logic [6:0] col,
                              input logic [7:0] val);
        pix_req_t p;
        p.src_row     = row;
        p.src_col     = col;
        p.pixel_value = val;
        start <= 1'b1;
        req   <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_random_pixel();
        send_pixel(7'($urandom), 7'($urandom), 8'($urandom));
    endtask

    // Drain the pipe: all results back, then an idle margin before returning
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Angle write; only called with the pipe drained
    task automatic write_angle(input logic [ANGLE_W-1:0] deg);
        if (idle_on)
            repeat ($urandom_range(1, 8)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= deg;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Corners and the canvas center at the current angle
    task automatic send_corners();
        send_pixel(7'd0,   7'd0,   8'h00);
        send_pixel(7'd127, 7'd127, 8'hFF);
        send_pixel(7'd0,   7'd127, 8'hAA);
        send_pixel(7'd127, 7'd0,   8'h55);
        send_pixel(7'd64,  7'd64,  8'h81);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        sb           = new();
        ncycles      = 0;
        angle_writes = 0;
        idle_on      = 1'b0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        req         <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset angle (identity), a quarter turn, 359, wrapped angles
        // 511 and 360, and a 45-degree diagonal applied to the edge midpoints.
        send_corners();
        wait_drained();
        write_angle(9'd90);
        send_corners();
        wait_drained();
        write_angle(9'd359);
        send_corners();
        wait_drained();
        idle_on = 1'b1;
        write_angle(9'd511);            // wraps to 151
        send_corners();
        wait_drained();
        write_angle(9'd45);
        send_pixel(7'd0,   7'd64, 8'h01);
        send_pixel(7'd127, 7'd64, 8'h80);
        send_pixel(7'd64,  7'd0,  8'h7F);
        wait_drained();
        write_angle(9'd360);            // wraps to identity
        send_pixel(7'd127, 7'd0,  8'hFE);
        send_pixel(7'd33,  7'd90, 8'h3C);
        wait_drained();

        // Random phases; the first five pin the angles 0, 511, 359, 180 and 270, and the
        // last two run at full rate with no idle bursts.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
            case (ph)
                0: write_angle(9'd0);
                1: write_angle(9'd511);
                2: write_angle(9'd359);
                3: write_angle(9'd180);
                4: write_angle(9'd270);
                default: write_angle(9'($urandom_range(0, 511)));
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++)
                send_random_pixel();
            wait_drained();
        end

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("Covered %0d pixel requests and %0d results over %0d angle settings",
                 sb.requests, sb.results, angle_writes + 1);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
sv/prm_pkg.sv
sv/prm_trig_rom.sv
sv/pixel_rotation_mapper_top.sv
verif/testbench.sv
